@@ src/octu_pkg.sv @@
// octu_pkg: shared types, constants and the latin-1 to utf-8 encoder
// used by the octal unescape decoder and the result emitter
// no dependencies
package octu_pkg;

  localparam logic [7:0] ESC_CHAR     = 8'h5C;
  localparam logic [7:0] TOO_BIG_CHAR = 8'h3F;
  localparam logic [1:0] LAST_DIGIT   = 2'd2;

  // one decoded byte re-encoded: one or two utf-8 bytes
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
  } lat_t;

  // results caused by one input transaction, in output order
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       fin;
  } dec_t;

  function automatic lat_t latin1(input logic [7:0] b);
    lat_t r;
    if (!b[7]) begin
      r.len = 2'd1;
      r.b0  = b;
      r.b1  = 8'h00;
    end else begin
      r.len = 2'd2;
      r.b0  = {2'b11, 4'b0000, b[7:6]};
      r.b1  = {2'b10, b[5:0]};
    end
    return r;
  endfunction

endpackage

@@ src/octu_dec.sv @@
// octu_dec: escape state and single-pass decode of one registered input byte
// into up to three utf-8 bytes; depends on octu_pkg
module octu_dec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  input  logic                take,
  output octu_pkg::dec_t      dec
);
  import octu_pkg::*;

  logic       in_escape_r, in_escape_nxt;
  logic [1:0] digit_count_r, digit_count_nxt;
  logic [8:0] octal_value_r, octal_value_nxt;
  logic       is_oct;
  logic [8:0] v;
  lat_t       lat_a, lat_b;

  assign is_oct = (text_byte[7:3] == 5'b00110);
  assign v      = {octal_value_r[5:0], text_byte[2:0]};

  always_comb begin
    lat_a           = '0;
    lat_b           = '0;
    in_escape_nxt   = in_escape_r;
    digit_count_nxt = digit_count_r;
    octal_value_nxt = octal_value_r;
    if (!in_escape_r) begin
      if (text_byte == ESC_CHAR) begin
        if (final_byte) begin
          lat_b = latin1(8'h00);
        end else begin
          in_escape_nxt   = 1'b1;
          digit_count_nxt = 2'd0;
          octal_value_nxt = 9'd0;
        end
      end else begin
        lat_b = latin1(text_byte);
      end
    end else if (is_oct) begin
      if (digit_count_r == LAST_DIGIT || final_byte) begin
        lat_a           = latin1(v[8] ? TOO_BIG_CHAR : v[7:0]);
        in_escape_nxt   = 1'b0;
        digit_count_nxt = 2'd0;
        octal_value_nxt = 9'd0;
      end else begin
        digit_count_nxt = digit_count_r + 2'd1;
        octal_value_nxt = v;
      end
    end else if (digit_count_r == 2'd0) begin
      // non-octal right after the backslash goes out as itself
      in_escape_nxt   = 1'b0;
      digit_count_nxt = 2'd0;
      octal_value_nxt = 9'd0;
      lat_b           = latin1(text_byte);
    end else begin
      // early end of escape, then the byte is handled as plain text
      in_escape_nxt   = 1'b0;
      digit_count_nxt = 2'd0;
      octal_value_nxt = 9'd0;
      lat_a = latin1(octal_value_r[8] ? TOO_BIG_CHAR : octal_value_r[7:0]);
      if (text_byte == ESC_CHAR) begin
        if (final_byte) begin
          lat_b = latin1(8'h00);
        end else begin
          in_escape_nxt = 1'b1;
        end
      end else begin
        lat_b = latin1(text_byte);
      end
    end
    if (final_byte) begin
      in_escape_nxt   = 1'b0;
      digit_count_nxt = 2'd0;
      octal_value_nxt = 9'd0;
    end
  end

  // a two-byte first part never has a second part (pending digits stay below 0x80)
  always_comb begin
    dec.cnt = lat_a.len + lat_b.len;
    dec.fin = final_byte;
    dec.b0  = (lat_a.len != 2'd0) ? lat_a.b0 : lat_b.b0;
    dec.b1  = (lat_a.len == 2'd2) ? lat_a.b1 :
              ((lat_a.len == 2'd1) ? lat_b.b0 : lat_b.b1);
    dec.b2  = lat_b.b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_escape_r   <= 1'b0;
      digit_count_r <= 2'd0;
      octal_value_r <= 9'd0;
    end else if (take) begin
      in_escape_r   <= in_escape_nxt;
      digit_count_r <= digit_count_nxt;
      octal_value_r <= octal_value_nxt;
    end
  end

endmodule

@@ src/octu_emit.sv @@
// octu_emit: result register holding up to three bytes of one input
// transaction, shifted out one per output transaction; depends on octu_pkg
module octu_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  octu_pkg::dec_t      dec,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_text_end
);
  import octu_pkg::*;

  logic [1:0] rem_r, rem_nxt;
  logic       fin_r;
  logic [7:0] buf0_r, buf1_r, buf2_r;
  logic       fire;

  assign out_valid    = (rem_r != 2'd0);
  assign fire         = out_valid && !out_stall;
  assign out_byte     = buf0_r;
  assign out_run_last = (rem_r == 2'd1);
  assign out_text_end = (rem_r == 2'd1) && fin_r;
  // free now, or the last byte leaves this cycle
  assign load_ok      = (rem_r == 2'd0) || ((rem_r == 2'd1) && !out_stall);

  always_comb begin
    rem_nxt = rem_r;
    if (take) begin
      rem_nxt = dec.cnt;
    end else if (fire) begin
      rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf0_r <= dec.b0;
      buf1_r <= dec.b1;
      buf2_r <= dec.b2;
      fin_r  <= dec.fin;
    end else if (fire) begin
      buf0_r <= buf1_r;
      buf1_r <= buf2_r;
    end
  end

endmodule

@@ src/octal_unescape_latin1_to_utf8.sv @@
// octal_unescape_latin1_to_utf8: top level, input register, decoder and emitter
// depends on octu_pkg, octu_dec, octu_emit
//
// Decodes backslash-octal escaped text and re-encodes each decoded byte from
// latin-1 to utf-8. One text byte is taken per cycle into an input register
// unless in_stall is high; the decoder turns the registered byte into zero to
// three utf-8 bytes, which load into a three-byte result register once it is
// free and leave one per cycle while out_stall is low. An input transaction
// that yields more than one byte keeps the next one waiting in the input
// register until its last byte leaves through the single output byte lane. A
// transaction with in_final_byte set always yields at least one byte, and its
// last byte carries out_text_end; escape state is then cleared for a new text.
module octal_unescape_latin1_to_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import octu_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_fin_r;
  logic       load_ok;
  logic       take;
  logic       accept;
  dec_t       dec;

  assign in_stall = s1_valid_r && !load_ok;
  assign accept   = in_valid && !in_stall;
  assign take     = s1_valid_r && load_ok;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_text_byte;
      s1_fin_r  <= in_final_byte;
    end
  end

  octu_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_byte  (s1_byte_r),
    .final_byte (s1_fin_r),
    .take       (take),
    .dec        (dec)
  );

  octu_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .dec          (dec),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  // the final byte of a text always produces a result
  a_fin_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && s1_fin_r |-> dec.cnt != 2'd0)
    else $error("final byte decoded to no result");

  // more bytes of the same input follow a non-last result
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("result run cut short");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("text end on a non-last result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid)
    else $error("input stalled with nothing pending");

endmodule

@@ sim/octal_unescape_latin1_to_utf8_tb.sv @@
// octal_unescape_latin1_to_utf8_tb: self-checking bench for the octal unescape
// and latin-1 to utf-8 re-encoder, directed table then random escape traffic
// depends on octu_pkg and octal_unescape_latin1_to_utf8
`timescale 1ns / 1ps

module octal_unescape_latin1_to_utf8_tb;
  import octu_pkg::*;

  localparam int         DIRECTED_ROWS = 25;
  localparam int         RANDOM_ITEMS  = 195;
  localparam int         MAX_DIGITS    = 3;
  localparam int         LONG_HOLD     = 200;
  localparam int         DRAIN_CYCLES  = 16;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam logic [7:0] DIGIT_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI      = 8'h37;

  typedef struct packed {
    logic [7:0]  text;
    logic        fin;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] bytes;
    logic        pause;
  } text_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } utf8_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_end;

  octal_unescape_latin1_to_utf8 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  text_row_t  stim_q[$];
  utf8_beat_t utf8_q[$];
  logic [7:0] beat_buf[$];

  // decoder state mirror
  logic       esc_open;
  logic [1:0] digits_seen;
  logic [8:0] value_acc;

  int         errors;
  int         beats_seen;
  int         cycles;
  int         next_idx;
  int         hold_at;
  int         burst_left;
  int         gap_left;
  int         hold_left;
  int         phase_left;
  logic       stall_phase;
  logic       hold_req;
  logic       hold_on;
  logic       pause_next;
  logic       took;
  text_row_t  cur_row;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", beats_seen, what, got, want);
    errors++;
  endtask

  function automatic void add_row(input logic [7:0] text, input logic fin, input logic typed,
                                  input logic [1:0] n, input logic [23:0] bytes);
    text_row_t r;
    r.text  = text;
    r.fin   = fin;
    r.typed = typed;
    r.n     = n;
    r.bytes = bytes;
    r.pause = pause_next;
    pause_next = 1'b0;
    stim_q.push_back(r);
  endfunction

  function automatic void add_checked(input logic [7:0] text, input logic fin);
    add_row(text, fin, 1'b0, 2'd0, 24'h0);
  endfunction

  function automatic void add_typed(input logic [7:0] text, input logic fin,
                                    input logic [1:0] n, input logic [23:0] bytes);
    add_row(text, fin, 1'b1, n, bytes);
  endfunction

  function automatic void drop_escape();
    esc_open    = 1'b0;
    digits_seen = 2'd0;
    value_acc   = 9'd0;
  endfunction

  function automatic void push_latin1(input logic [7:0] b);
    if (!b[7]) begin
      beat_buf.push_back(b);
    end else begin
      beat_buf.push_back({6'b110000, b[7:6]});
      beat_buf.push_back({2'b10, b[5:0]});
    end
  endfunction

  function automatic void push_value(input logic [8:0] v);
    push_latin1(v > 9'd255 ? TOO_BIG_CHAR : v[7:0]);
  endfunction

  function automatic void take_plain(input logic [7:0] b, input logic fin);
    if (b == ESC_CHAR) begin
      // a backslash at the very end stands for a nul byte
      if (fin) begin
        push_latin1(8'h00);
      end else begin
        esc_open    = 1'b1;
        digits_seen = 2'd0;
        value_acc   = 9'd0;
      end
    end else begin
      push_latin1(b);
    end
  endfunction

  function automatic void decode_text_byte(input logic [7:0] b, input logic fin);
    logic [8:0] v;
    logic [2:0] n;
    beat_buf.delete();
    if (!esc_open) begin
      take_plain(b, fin);
    end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
      v = {value_acc[5:0], 3'b000} + {6'd0, b[2:0]};
      n = digits_seen + 3'd1;
      if (n >= MAX_DIGITS || fin) begin
        push_value(v);
        drop_escape();
      end else begin
        digits_seen = n[1:0];
        value_acc   = v;
      end
    end else if (digits_seen == 2'd0) begin
      drop_escape();
      push_latin1(b);
    end else begin
      // early terminator: flush digits, then the byte stands on its own
      v = value_acc;
      drop_escape();
      push_value(v);
      take_plain(b, fin);
    end
    if (fin) drop_escape();
  endfunction

  function automatic void queue_beats(input logic fin);
    utf8_beat_t w;
    for (int i = 0; i < beat_buf.size(); i++) begin
      w.data     = beat_buf[i];
      w.run_last = (i == beat_buf.size() - 1);
      w.text_end = w.run_last && fin;
      utf8_q.push_back(w);
    end
  endfunction

  task automatic check_beat();
    utf8_beat_t want;
    if (utf8_q.size() == 0) begin
      report_mismatch("result with nothing expected, out_byte", out_byte, 8'h00);
    end else begin
      want = utf8_q.pop_front();
      if (out_byte !== want.data)
        report_mismatch("out_byte", out_byte, want.data);
      if (out_run_last !== want.run_last)
        report_mismatch("out_run_last", {7'd0, out_run_last}, {7'd0, want.run_last});
      if (out_text_end !== want.text_end)
        report_mismatch("out_text_end", {7'd0, out_text_end}, {7'd0, want.text_end});
    end
    beats_seen++;
  endtask

  // sender and checker
  always @(posedge clk) begin
    cycles++;
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_req <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_beat();
      took = in_valid && !in_stall;
      if (took) begin
        cur_row = stim_q[next_idx];
        decode_text_byte(cur_row.text, cur_row.fin);
        if (cur_row.typed) begin
          beat_buf.delete();
          for (int i = 0; i < cur_row.n; i++) beat_buf.push_back(cur_row.bytes[23 - 8 * i -: 8]);
        end
        queue_beats(cur_row.fin);
        next_idx++;
      end
      hold_req <= took && (next_idx == hold_at);
      if (!in_valid || took) begin
        // keep offering without gaps while the receiver holds off
        if (hold_on) gap_left = 0;
        if (next_idx < stim_q.size() && gap_left == 0 &&
            !(stim_q[next_idx].pause && utf8_q.size() != 0)) begin
          in_valid      <= 1'b1;
          in_text_byte  <= stim_q[next_idx].text;
          in_final_byte <= stim_q[next_idx].fin;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(20, 40);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = $urandom_range(1, 4);
            end
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_on   <= 1'b0;
    end else begin
      if (hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
        hold_on   <= 1'b1;
      end else begin
        hold_on <= 1'b0;
        if (phase_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              stall_phase = 1'b1;
              phase_left  = $urandom_range(1, 4);
            end
            8, 9: begin
              stall_phase = 1'b0;
              phase_left  = $urandom_range(20, 50);
            end
            default: begin
              stall_phase = 1'b0;
              phase_left  = $urandom_range(1, 6);
            end
          endcase
        end
        phase_left--;
        out_stall <= stall_phase;
      end
    end
  end

  initial begin
    logic [7:0] chunk[$];
    int         kind;
    int         ndig;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_text_byte  = 8'h00;
    in_final_byte = 1'b0;
    out_stall     = 1'b0;
    hold_req      = 1'b0;
    hold_on       = 1'b0;
    errors        = 0;
    beats_seen    = 0;
    cycles        = 0;
    next_idx      = 0;
    burst_left    = 1;
    gap_left      = 0;
    hold_left     = 0;
    phase_left    = 0;
    stall_phase   = 1'b0;
    pause_next    = 1'b0;
    drop_escape();

    // extremes of the byte range and the zero byte
    add_typed(8'h01, 1'b0, 2'd1, {8'h01, 16'h0});
    add_typed(8'hFF, 1'b0, 2'd2, {8'hC3, 8'hBF, 8'h00});
    add_typed(8'h80, 1'b0, 2'd2, {8'hC2, 8'h80, 8'h00});
    add_typed(8'h00, 1'b0, 2'd1, 24'h0);
    // three-digit escape, then one worth more than a byte
    add_typed(ESC_CHAR, 1'b0, 2'd0, 24'h0);
    add_typed("1", 1'b0, 2'd0, 24'h0);
    add_typed("0", 1'b0, 2'd0, 24'h0);
    add_typed("1", 1'b0, 2'd1, {8'h41, 16'h0});
    add_typed(ESC_CHAR, 1'b0, 2'd0, 24'h0);
    add_typed("7", 1'b0, 2'd0, 24'h0);
    add_typed("7", 1'b0, 2'd0, 24'h0);
    add_typed("7", 1'b0, 2'd1, {TOO_BIG_CHAR, 16'h0});
    // escaped backslash, early terminators, new escape as terminator
    add_checked(ESC_CHAR, 1'b0);
    add_checked(ESC_CHAR, 1'b0);
    add_checked(ESC_CHAR, 1'b0);
    add_checked("1", 1'b0);
    add_checked("x", 1'b0);
    add_checked(ESC_CHAR, 1'b0);
    add_checked("2", 1'b0);
    add_checked(ESC_CHAR, 1'b0);
    add_checked("6", 1'b1);
    // lone backslash at the end, then digits pending at the end
    add_typed(ESC_CHAR, 1'b1, 2'd1, 24'h0);
    add_checked(ESC_CHAR, 1'b0);
    add_checked("1", 1'b0);
    add_checked("2", 1'b1);

    hold_at    = DIRECTED_ROWS + 40;
    pause_next = 1'b1;
    while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if (stim_q.size() >= DIRECTED_ROWS + RANDOM_ITEMS / 2 &&
          stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS / 2 + 4)
        pause_next = 1'b1;
      chunk.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: chunk.push_back(8'($urandom_range(1, 255)));
        3, 4, 5: begin
          chunk.push_back(ESC_CHAR);
          for (int i = 0; i < MAX_DIGITS; i++) chunk.push_back(DIGIT_LO + 8'($urandom_range(0, 7)));
        end
        6, 7: begin
          ndig = $urandom_range(1, 2);
          chunk.push_back(ESC_CHAR);
          for (int i = 0; i < ndig; i++) chunk.push_back(DIGIT_LO + 8'($urandom_range(0, 7)));
          chunk.push_back(8'($urandom_range(1, 255)));
        end
        8: begin
          chunk.push_back(ESC_CHAR);
          chunk.push_back(8'($urandom_range(1, 255)));
        end
        default: chunk.push_back(ESC_CHAR);
      endcase
      for (int i = 0; i < chunk.size(); i++)
        add_checked(chunk[i], (i == chunk.size() - 1) && ($urandom_range(0, 5) == 0));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (!(next_idx == stim_q.size() && utf8_q.size() == 0) && cycles < CYCLE_LIMIT)
      @(negedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (errors == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/octu_pkg.sv
src/octu_dec.sv
src/octu_emit.sv
src/octal_unescape_latin1_to_utf8.sv
sim/octal_unescape_latin1_to_utf8_tb.sv
